>>> hdl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the sparse polynomial multiplier
// Item codes, queue entry type and default sizes.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int unsigned MAX_TERMS_DEF = 8;
  localparam int unsigned COEFF_W       = 16;
  localparam int unsigned POWER_W       = 8;
  localparam int unsigned PCOEFF_W      = 32;
  localparam int unsigned PPOWER_W      = 9;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  // one classified beat as it travels from front to back
  typedef struct packed {
    action_e                    act;
    logic signed [COEFF_W-1:0]  coeff;
    logic [POWER_W-1:0]         power;
  } cmd_t;

endpackage

>>> hdl/sparse_polynomial_multiply_unit.sv
`timescale 1ns / 1ps
// Latency: a load beat goes through the command queue and, once the engine is idle, into its
// term store; a compute beat gives its first result after two walks of all P term pairs, P = pairs.
// Throughput: loads 1 per cycle while no compute is running; compute needs one walk of all P term
// pairs (one pair a cycle through the multiplier) per output term, plus one.
// Reset: asynchronous, active low; queue, counts, flag and output emptied.
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply_unit: sparse polynomial multiplier top level
// Front classifier, command queue and product engine.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply_unit #(
  parameter int unsigned MaxTerms = spm_pkg::MAX_TERMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] term_coeff_i,
  input  logic [7:0]         term_power_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_coeff_o,
  output logic [8:0]         out_power_o,
  output logic               is_last_o,
  output logic               is_empty_o,
  output logic               overflowed_o
);
  import spm_pkg::*;

  logic wr, rd, vld;
  cmd_t wcmd, rcmd;

  spm_front u_front (
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .term_coeff_i (term_coeff_i),
    .term_power_i (term_power_i),
    .wr_o         (wr),
    .cmd_o        (wcmd)
  );

  spm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wcmd),
    .full_o  (full),
    .rd_i    (rd),
    .vld_o   (vld),
    .rdata_o (rcmd)
  );

  spm_back #(.MaxTerms(MaxTerms)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (vld),
    .cmd_i        (rcmd),
    .rd_o         (rd),
    .empty        (empty),
    .pop          (pop),
    .out_coeff_o  (out_coeff_o),
    .out_power_o  (out_power_o),
    .is_last_o    (is_last_o),
    .is_empty_o   (is_empty_o),
    .overflowed_o (overflowed_o)
  );

endmodule

>>> hdl/spm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_front: input classifier
// Takes input beats, drops unused codes and builds queue entries.
// ----------------------------------------------------------------------------
module spm_front (
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] term_coeff_i,
  input  logic [7:0]         term_power_i,
  output logic               wr_o,
  output spm_pkg::cmd_t      cmd_o
);
  import spm_pkg::*;

  logic known;

  // codes 0..2 are work; anything else is taken and discarded
  always_comb begin
    unique case (action_i)
      ACT_LOAD_A, ACT_LOAD_B, ACT_COMPUTE: known = 1'b1;
      default:                             known = 1'b0;
    endcase
  end

  assign wr_o        = push && !full && known;
  assign cmd_o.act   = action_e'(action_i);
  assign cmd_o.coeff = term_coeff_i;
  assign cmd_o.power = term_power_i;

endmodule

>>> hdl/spm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_fifo: two-entry command queue
// Decouples the classifier from the compute engine.
// ----------------------------------------------------------------------------
module spm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  spm_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          vld_o,
  output spm_pkg::cmd_t rdata_o
);
  import spm_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign vld_o   = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

>>> hdl/spm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_back: term stores and product engine
// Holds loaded terms; for a compute beat walks all term pairs once per
// output term and once more, each walk finding the next lower power and its sum.
// ----------------------------------------------------------------------------
module spm_back #(
  parameter int unsigned MaxTerms = spm_pkg::MAX_TERMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  spm_pkg::cmd_t      cmd_i,
  output logic               rd_o,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_coeff_o,
  output logic [8:0]         out_power_o,
  output logic               is_last_o,
  output logic               is_empty_o,
  output logic               overflowed_o
);
  import spm_pkg::*;

  localparam int unsigned IW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned CW = $clog2(MaxTerms + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxTerms);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WALK    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // term stores
  logic signed [COEFF_W-1:0] a_coef_q [MaxTerms];
  logic [POWER_W-1:0]        a_pow_q  [MaxTerms];
  logic signed [COEFF_W-1:0] b_coef_q [MaxTerms];
  logic [POWER_W-1:0]        b_pow_q  [MaxTerms];
  logic [CW-1:0]             a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic                      ovf_q, ovf_d;
  logic                      a_we, b_we;

  logic [2:0]                state_q, state_d;
  logic [IW-1:0]             i_q, i_d, j_q, j_d;

  // multiply stage
  logic                      v1_q, v1_d;
  logic signed [31:0]        prod1_q;
  logic [PPOWER_W-1:0]       pw1_q;

  // walk accumulator
  logic                      fnd_q, fnd_d;
  logic [PPOWER_W-1:0]       bpw_q, bpw_d;
  logic signed [31:0]        bsum_q, bsum_d;
  logic [PPOWER_W:0]         lim_q, lim_d;

  // term found by the previous walk, not yet sent
  logic                      pv_q, pv_d;
  logic [PPOWER_W-1:0]       ppw_q, ppw_d;
  logic signed [31:0]        psum_q, psum_d;

  // output register
  logic                      ov_q, ov_d;
  logic signed [31:0]        oc_q, oc_d;
  logic [PPOWER_W-1:0]       op_q, op_d;
  logic                      ol_q, ol_d, oe_q, oe_d, oo_q, oo_d;
  logic                      slot_free, last_j, last_i;

  assign slot_free = !ov_q || pop;
  assign last_j    = (CW'(j_q) + CW'(1)) == b_cnt_q;
  assign last_i    = (CW'(i_q) + CW'(1)) == a_cnt_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    rd_o    = 1'b0;
    a_we    = 1'b0;
    b_we    = 1'b0;
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    v1_d    = 1'b0;
    fnd_d   = fnd_q;
    bpw_d   = bpw_q;
    bsum_d  = bsum_q;
    lim_d   = lim_q;
    pv_d    = pv_q;
    ppw_d   = ppw_q;
    psum_d  = psum_q;
    ov_d    = ov_q && !pop;
    oc_d    = oc_q;
    op_d    = op_q;
    ol_d    = ol_q;
    oe_d    = oe_q;
    oo_d    = oo_q;

    // accumulate the pair leaving the multiply stage
    if (v1_q && ({1'b0, pw1_q} < lim_q)) begin
      if (!fnd_q || (pw1_q > bpw_q)) begin
        fnd_d  = 1'b1;
        bpw_d  = pw1_q;
        bsum_d = prod1_q;
      end else if (pw1_q == bpw_q) begin
        bsum_d = bsum_q + prod1_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (vld_i) begin
          rd_o = 1'b1;
          unique case (cmd_i.act)
            ACT_LOAD_A: begin
              if (a_cnt_q == CntMax) ovf_d = 1'b1;
              else begin
                a_we    = 1'b1;
                a_cnt_d = a_cnt_q + CW'(1);
              end
            end
            ACT_LOAD_B: begin
              if (b_cnt_q == CntMax) ovf_d = 1'b1;
              else begin
                b_we    = 1'b1;
                b_cnt_d = b_cnt_q + CW'(1);
              end
            end
            default: begin
              if (a_cnt_q == '0 || b_cnt_q == '0) state_d = ST_EMPTY;
              else begin
                state_d = ST_WALK;
                i_d     = '0;
                j_d     = '0;
                fnd_d   = 1'b0;
                pv_d    = 1'b0;
                lim_d   = {1'b0, {PPOWER_W{1'b1}}};
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        v1_d = 1'b1;
        if (last_j) begin
          j_d = '0;
          if (last_i) state_d = ST_DRAIN;
          else        i_d     = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!v1_q) state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (fnd_q) begin
          if (!pv_q || slot_free) begin
            if (pv_q) begin
              ov_d = 1'b1;
              oc_d = psum_q;
              op_d = ppw_q;
              ol_d = 1'b0;
              oe_d = 1'b0;
              oo_d = ovf_q;
            end
            pv_d    = 1'b1;
            ppw_d   = bpw_q;
            psum_d  = bsum_q;
            lim_d   = {1'b0, bpw_q};
            fnd_d   = 1'b0;
            i_d     = '0;
            j_d     = '0;
            state_d = ST_WALK;
          end
        end else if (slot_free) begin
          ov_d    = 1'b1;
          oc_d    = psum_q;
          op_d    = ppw_q;
          ol_d    = 1'b1;
          oe_d    = 1'b0;
          oo_d    = ovf_q;
          a_cnt_d = '0;
          b_cnt_d = '0;
          ovf_d   = 1'b0;
          pv_d    = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oc_d    = '0;
          op_d    = '0;
          ol_d    = 1'b1;
          oe_d    = 1'b1;
          oo_d    = ovf_q;
          a_cnt_d = '0;
          b_cnt_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
      v1_q    <= 1'b0;
      fnd_q   <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      ovf_q   <= ovf_d;
      v1_q    <= v1_d;
      fnd_q   <= fnd_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  // payload: stores, multiply stage, accumulators, output beat
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_coef_q[a_cnt_q[IW-1:0]] <= cmd_i.coeff;
      a_pow_q[a_cnt_q[IW-1:0]]  <= cmd_i.power;
    end
    if (b_we) begin
      b_coef_q[b_cnt_q[IW-1:0]] <= cmd_i.coeff;
      b_pow_q[b_cnt_q[IW-1:0]]  <= cmd_i.power;
    end
    prod1_q <= a_coef_q[i_q] * b_coef_q[j_q];
    pw1_q   <= {1'b0, a_pow_q[i_q]} + {1'b0, b_pow_q[j_q]};
    i_q     <= i_d;
    j_q     <= j_d;
    bpw_q   <= bpw_d;
    bsum_q  <= bsum_d;
    lim_q   <= lim_d;
    ppw_q   <= ppw_d;
    psum_q  <= psum_d;
    oc_q    <= oc_d;
    op_q    <= op_d;
    ol_q    <= ol_d;
    oe_q    <= oe_d;
    oo_q    <= oo_d;
  end

  assign empty        = !ov_q;
  assign out_coeff_o  = oc_q;
  assign out_power_o  = op_q;
  assign is_last_o    = ol_q;
  assign is_empty_o   = oe_q;
  assign overflowed_o = oo_q;

endmodule

>>> hdl/spm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_checker: port-level checks of the multiplier
// Result beat hold rules and the form of the empty-product beat.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_coeff_o,
  input logic [8:0]         out_power_o,
  input logic               is_last_o,
  input logic               is_empty_o
);

  // a waiting result stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result beat withdrawn");

  // a stalled result keeps its payload
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_coeff_o) && $stable(out_power_o))
    else $error("stalled result changed");

  // an empty product is one final beat of zeros
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_empty_o |-> is_last_o && out_coeff_o == 32'sd0 && out_power_o == 9'd0)
    else $error("malformed empty product");

  // within one product, powers fall strictly from beat to beat
  a_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !is_last_o ##1 !empty |-> out_power_o < $past(out_power_o))
    else $error("powers not descending");

endmodule

bind sparse_polynomial_multiply_unit spm_checker u_spm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .out_coeff_o (out_coeff_o),
  .out_power_o (out_power_o),
  .is_last_o   (is_last_o),
  .is_empty_o  (is_empty_o)
);
